@@ rtl/pidpl_pkg.sv @@
package pidpl_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    // register field widths
    localparam int SETPOINT_WIDTH = 16;
    localparam int GAIN_WIDTH     = 32;
    localparam int WINDOW_WIDTH   = 16;
    localparam int LIMIT_WIDTH    = 24;

    // error sum: clamped to +-limit, one guard bit for the add before the clamp
    localparam int SUM_WIDTH  = LIMIT_WIDTH + 1;
    localparam int ACC_WIDTH  = SUM_WIDTH + 1;
    // an accumulated error is below the window, so it fits in this many bits
    localparam int STEP_WIDTH = WINDOW_WIDTH + 1;

    // each scaled term saturates at magnitude 2^61
    localparam int TERM_WIDTH = 62;
    localparam logic [TERM_WIDTH-1:0] TERM_CAP = {1'b1, {(TERM_WIDTH-1){1'b0}}};
    localparam int RAW_WIDTH  = 64;

    // result widths
    localparam int DRIVE_WIDTH     = 8;
    localparam int DRIVE_MAG_WIDTH = 16;

    // register indexes
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SETPOINT          = 3'd0,
        REG_PROPORTIONAL_GAIN = 3'd1,
        REG_INTEGRAL_GAIN     = 3'd2,
        REG_DERIVATIVE_GAIN   = 3'd3,
        REG_INTEGRAL_WINDOW   = 3'd4,
        REG_INTEGRAL_LIMIT    = 3'd5
    } reg_index_t;

    // reset values
    localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd200;
    localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET  = 24'd5000000;

    typedef struct packed {
        logic signed [SETPOINT_WIDTH-1:0] setpoint;
        logic [GAIN_WIDTH-1:0]            proportional_gain;
        logic [GAIN_WIDTH-1:0]            integral_gain;
        logic [GAIN_WIDTH-1:0]            derivative_gain;
        logic [WINDOW_WIDTH-1:0]          integral_window;
        logic [LIMIT_WIDTH-1:0]           integral_limit;
    } cfg_t;

    // pipeline load enables
    typedef struct packed {
        logic load_in;
        logic commit;
        logic load_err;
        logic load_prod;
        logic load_raw;
        logic load_out;
    } adv_t;

endpackage

@@ rtl/pidpl_error.sv @@
module pidpl_error
    import pidpl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int ERR_WIDTH    = 17,
    parameter int DIFF_WIDTH   = 18
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  adv_t                    adv,
    input  cfg_t                    cfg,
    input  logic [SAMPLE_WIDTH-1:0] measurement,
    output logic                    err_neg,
    output logic [ERR_WIDTH-1:0]    err_mag,
    output logic                    sum_neg,
    output logic [SUM_WIDTH-1:0]    sum_mag,
    output logic                    diff_neg,
    output logic [DIFF_WIDTH-1:0]   diff_mag
);

    logic signed [SAMPLE_WIDTH-1:0] meas_reg;
    logic signed [ERR_WIDTH-1:0]    prev_err_reg;
    logic signed [SUM_WIDTH-1:0]    sum_reg;
    logic                           err_neg_reg;
    logic [ERR_WIDTH-1:0]           err_mag_reg;
    logic                           sum_neg_reg;
    logic [SUM_WIDTH-1:0]           sum_mag_reg;
    logic                           diff_neg_reg;
    logic [DIFF_WIDTH-1:0]          diff_mag_reg;

    logic signed [ERR_WIDTH-1:0]    err;
    logic [ERR_WIDTH-1:0]           err_abs;
    logic                           accumulate;
    logic signed [ACC_WIDTH-1:0]    sum_wide;
    logic signed [ACC_WIDTH-1:0]    limit_pos;
    logic signed [ACC_WIDTH-1:0]    limit_neg;
    logic signed [SUM_WIDTH-1:0]    sum_next;
    logic [SUM_WIDTH-1:0]           sum_abs;
    logic signed [DIFF_WIDTH-1:0]   diff;
    logic [DIFF_WIDTH-1:0]          diff_abs;

    // error and window test
    always_comb
    begin
        err        = ERR_WIDTH'(cfg.setpoint) - ERR_WIDTH'(meas_reg);
        err_abs    = err[ERR_WIDTH-1] ? -err : err;
        accumulate = (err != '0) && (err_abs < ERR_WIDTH'(cfg.integral_window));
    end

    // running sum with clamp, cleared on zero error or outside the window
    always_comb
    begin
        sum_wide  = ACC_WIDTH'(sum_reg) + ACC_WIDTH'($signed(err[STEP_WIDTH-1:0]));
        limit_pos = $signed({2'b00, cfg.integral_limit});
        limit_neg = -limit_pos;
        if (!accumulate)
        begin
            sum_next = '0;
        end
        else if (sum_wide > limit_pos)
        begin
            sum_next = SUM_WIDTH'(limit_pos);
        end
        else if (sum_wide < limit_neg)
        begin
            sum_next = SUM_WIDTH'(limit_neg);
        end
        else
        begin
            sum_next = SUM_WIDTH'(sum_wide);
        end
        sum_abs = sum_next[SUM_WIDTH-1] ? -sum_next : sum_next;
    end

    // error difference for the derivative term
    always_comb
    begin
        diff     = DIFF_WIDTH'(err) - DIFF_WIDTH'(prev_err_reg);
        diff_abs = diff[DIFF_WIDTH-1] ? -diff : diff;
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (adv.load_in)
        begin
            meas_reg <= $signed(measurement);
        end
    end

    // loop state, updated once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg <= '0;
            sum_reg      <= '0;
        end
        else if (adv.commit)
        begin
            prev_err_reg <= err;
            sum_reg      <= sum_next;
        end
    end

    // sign and magnitude of the three term operands
    always_ff @(posedge clk)
    begin
        if (adv.load_err)
        begin
            err_neg_reg  <= err[ERR_WIDTH-1];
            err_mag_reg  <= err_abs;
            sum_neg_reg  <= sum_next[SUM_WIDTH-1];
            sum_mag_reg  <= sum_abs;
            diff_neg_reg <= diff[DIFF_WIDTH-1];
            diff_mag_reg <= diff_abs;
        end
    end

    assign err_neg  = err_neg_reg;
    assign err_mag  = err_mag_reg;
    assign sum_neg  = sum_neg_reg;
    assign sum_mag  = sum_mag_reg;
    assign diff_neg = diff_neg_reg;
    assign diff_mag = diff_mag_reg;

    // state only moves with a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv.commit |=> $stable(prev_err_reg) && $stable(sum_reg))
        else $error("loop state changed without a transaction");

    // the clamp keeps the sum off the most negative code
    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg != {1'b1, {(SUM_WIDTH-1){1'b0}}})
        else $error("error sum escaped the clamp");

endmodule

@@ rtl/pidpl_terms.sv @@
module pidpl_terms
    import pidpl_pkg::*;
#(
    parameter int ERR_WIDTH  = 17,
    parameter int DIFF_WIDTH = 18
)
(
    input  logic                        clk,
    input  adv_t                        adv,
    input  cfg_t                        cfg,
    input  logic                        err_neg,
    input  logic [ERR_WIDTH-1:0]        err_mag,
    input  logic                        sum_neg,
    input  logic [SUM_WIDTH-1:0]        sum_mag,
    input  logic                        diff_neg,
    input  logic [DIFF_WIDTH-1:0]       diff_mag,
    output logic signed [RAW_WIDTH-1:0] raw
);

    localparam int PW_P = GAIN_WIDTH + ERR_WIDTH;
    localparam int PW_I = GAIN_WIDTH + SUM_WIDTH;
    localparam int PW_D = GAIN_WIDTH + DIFF_WIDTH;
    localparam int TW_P = (PW_P > TERM_WIDTH) ? PW_P : TERM_WIDTH;
    localparam int TW_I = (PW_I > TERM_WIDTH) ? PW_I : TERM_WIDTH;
    localparam int TW_D = (PW_D > TERM_WIDTH) ? PW_D : TERM_WIDTH;

    logic [PW_P-1:0]             prod_p_reg;
    logic [PW_I-1:0]             prod_i_reg;
    logic [PW_D-1:0]             prod_d_reg;
    logic                        neg_p_reg;
    logic                        neg_i_reg;
    logic                        neg_d_reg;
    logic signed [RAW_WIDTH-1:0] raw_reg;

    logic [TW_P-1:0]             ext_p;
    logic [TW_I-1:0]             ext_i;
    logic [TW_D-1:0]             ext_d;
    logic [TERM_WIDTH-1:0]       mag_p;
    logic [TERM_WIDTH-1:0]       mag_i;
    logic [TERM_WIDTH-1:0]       mag_d;
    logic signed [RAW_WIDTH-1:0] term_p;
    logic signed [RAW_WIDTH-1:0] term_i;
    logic signed [RAW_WIDTH-1:0] term_d;

    // gain times magnitude, one multiplier per term
    always_ff @(posedge clk)
    begin
        if (adv.load_prod)
        begin
            prod_p_reg <= PW_P'(cfg.proportional_gain) * PW_P'(err_mag);
            prod_i_reg <= PW_I'(cfg.integral_gain) * PW_I'(sum_mag);
            prod_d_reg <= PW_D'(cfg.derivative_gain) * PW_D'(diff_mag);
            neg_p_reg  <= err_neg;
            neg_i_reg  <= sum_neg;
            neg_d_reg  <= diff_neg;
        end
    end

    // cap each term, restore its sign and add
    always_comb
    begin
        ext_p  = TW_P'(prod_p_reg);
        ext_i  = TW_I'(prod_i_reg);
        ext_d  = TW_D'(prod_d_reg);
        mag_p  = (ext_p > TW_P'(TERM_CAP)) ? TERM_CAP : ext_p[TERM_WIDTH-1:0];
        mag_i  = (ext_i > TW_I'(TERM_CAP)) ? TERM_CAP : ext_i[TERM_WIDTH-1:0];
        mag_d  = (ext_d > TW_D'(TERM_CAP)) ? TERM_CAP : ext_d[TERM_WIDTH-1:0];
        term_p = neg_p_reg ? -$signed(RAW_WIDTH'(mag_p)) : $signed(RAW_WIDTH'(mag_p));
        term_i = neg_i_reg ? -$signed(RAW_WIDTH'(mag_i)) : $signed(RAW_WIDTH'(mag_i));
        term_d = neg_d_reg ? -$signed(RAW_WIDTH'(mag_d)) : $signed(RAW_WIDTH'(mag_d));
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_raw)
        begin
            raw_reg <= term_p + term_i + term_d;
        end
    end

    assign raw = raw_reg;

endmodule

@@ rtl/pidpl_output.sv @@
module pidpl_output
    import pidpl_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = 24,
    parameter int OUTPUT_LIMIT       = 127
)
(
    input  logic                        clk,
    input  adv_t                        adv,
    input  logic signed [RAW_WIDTH-1:0] raw,
    output logic [DRIVE_WIDTH-1:0]      drive,
    output logic                        saturated
);

    logic [DRIVE_WIDTH-1:0]     drive_reg;
    logic                       sat_reg;

    logic                       raw_neg;
    logic [RAW_WIDTH-1:0]       raw_abs;
    logic [RAW_WIDTH-1:0]       whole;
    logic                       over;
    logic [DRIVE_MAG_WIDTH-1:0] drive_mag;
    logic [DRIVE_MAG_WIDTH-1:0] drive_wide;

    // truncate toward zero, then saturate the magnitude
    always_comb
    begin
        raw_neg    = raw[RAW_WIDTH-1];
        raw_abs    = raw_neg ? -raw : raw;
        whole      = raw_abs >> GAIN_FRACTION_BITS;
        over       = whole > RAW_WIDTH'(OUTPUT_LIMIT);
        drive_mag  = over ? DRIVE_MAG_WIDTH'(OUTPUT_LIMIT) : whole[DRIVE_MAG_WIDTH-1:0];
        drive_wide = raw_neg ? -drive_mag : drive_mag;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (adv.load_out)
        begin
            drive_reg <= drive_wide[DRIVE_WIDTH-1:0];
            sat_reg   <= over;
        end
    end

    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule

@@ rtl/pid_position_loop.sv @@
// throughput: one sample per cycle while out_ready holds no result back; five
// register stages (input, error and sum, products, raw sum, result) move forward
// whenever the stage ahead frees up
// reset: clears all stage valid flags, the previous error and the error sum, and
// loads the register defaults (setpoint and gains 0, window 200, limit 5000000)
module pid_position_loop
    import pidpl_pkg::*;
#(
    parameter int SAMPLE_WIDTH       = 16,
    parameter int GAIN_FRACTION_BITS = 24,
    parameter int OUTPUT_LIMIT       = 127
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_WIDTH-1:0]    measurement,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DRIVE_WIDTH-1:0]     drive,
    output logic                       saturated
);

    localparam int ERR_WIDTH  =
        ((SAMPLE_WIDTH > SETPOINT_WIDTH) ? SAMPLE_WIDTH : SETPOINT_WIDTH) + 1;
    localparam int DIFF_WIDTH = ERR_WIDTH + 1;

    cfg_t                  cfg_reg;
    adv_t                  adv;
    logic                  in_vld_reg;
    logic                  err_vld_reg;
    logic                  prod_vld_reg;
    logic                  raw_vld_reg;
    logic                  out_vld_reg;

    logic                  err_neg;
    logic [ERR_WIDTH-1:0]  err_mag;
    logic                  sum_neg;
    logic [SUM_WIDTH-1:0]  sum_mag;
    logic                  diff_neg;
    logic [DIFF_WIDTH-1:0] diff_mag;
    logic signed [RAW_WIDTH-1:0] raw;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint          <= '0;
            cfg_reg.proportional_gain <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.derivative_gain   <= '0;
            cfg_reg.integral_window   <= WINDOW_RESET;
            cfg_reg.integral_limit    <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_SETPOINT:
                    cfg_reg.setpoint <= $signed(cfg_data[SETPOINT_WIDTH-1:0]);
                REG_PROPORTIONAL_GAIN:
                    cfg_reg.proportional_gain <= cfg_data[GAIN_WIDTH-1:0];
                REG_INTEGRAL_GAIN:
                    cfg_reg.integral_gain <= cfg_data[GAIN_WIDTH-1:0];
                REG_DERIVATIVE_GAIN:
                    cfg_reg.derivative_gain <= cfg_data[GAIN_WIDTH-1:0];
                REG_INTEGRAL_WINDOW:
                    cfg_reg.integral_window <= cfg_data[WINDOW_WIDTH-1:0];
                REG_INTEGRAL_LIMIT:
                    cfg_reg.integral_limit <= cfg_data[LIMIT_WIDTH-1:0];
                default:
                    ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb
    begin
        adv.load_out  = !out_vld_reg || out_ready;
        adv.load_raw  = !raw_vld_reg || adv.load_out;
        adv.load_prod = !prod_vld_reg || adv.load_raw;
        adv.load_err  = !err_vld_reg || adv.load_prod;
        adv.load_in   = !in_vld_reg || adv.load_err;
        adv.commit    = adv.load_err && in_vld_reg;
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            err_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            raw_vld_reg  <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (adv.load_in)
            begin
                in_vld_reg <= in_valid;
            end
            if (adv.load_err)
            begin
                err_vld_reg <= in_vld_reg;
            end
            if (adv.load_prod)
            begin
                prod_vld_reg <= err_vld_reg;
            end
            if (adv.load_raw)
            begin
                raw_vld_reg <= prod_vld_reg;
            end
            if (adv.load_out)
            begin
                out_vld_reg <= raw_vld_reg;
            end
        end
    end

    assign in_ready  = adv.load_in;
    assign out_valid = out_vld_reg;

    // error, window and running sum
    pidpl_error #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ERR_WIDTH    (ERR_WIDTH),
        .DIFF_WIDTH   (DIFF_WIDTH)
    ) u_error (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .cfg         (cfg_reg),
        .measurement (measurement),
        .err_neg     (err_neg),
        .err_mag     (err_mag),
        .sum_neg     (sum_neg),
        .sum_mag     (sum_mag),
        .diff_neg    (diff_neg),
        .diff_mag    (diff_mag)
    );

    // gain products and their sum
    pidpl_terms #(
        .ERR_WIDTH  (ERR_WIDTH),
        .DIFF_WIDTH (DIFF_WIDTH)
    ) u_terms (
        .clk      (clk),
        .adv      (adv),
        .cfg      (cfg_reg),
        .err_neg  (err_neg),
        .err_mag  (err_mag),
        .sum_neg  (sum_neg),
        .sum_mag  (sum_mag),
        .diff_neg (diff_neg),
        .diff_mag (diff_mag),
        .raw      (raw)
    );

    // truncation and saturation
    pidpl_output #(
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS),
        .OUTPUT_LIMIT       (OUTPUT_LIMIT)
    ) u_output (
        .clk       (clk),
        .adv       (adv),
        .raw       (raw),
        .drive     (drive),
        .saturated (saturated)
    );

    // a full, stalled pipeline takes no new transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && err_vld_reg && prod_vld_reg && raw_vld_reg && out_vld_reg
            && !out_ready) |-> !in_ready)
        else $error("transaction accepted into a full pipeline");

    // a result only appears from a filled raw stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(raw_vld_reg))
        else $error("result offered without an item behind it");

    // a saturated result sits at the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (drive == DRIVE_WIDTH'(OUTPUT_LIMIT) || drive == DRIVE_WIDTH'(-OUTPUT_LIMIT)))
        else $error("saturated result off the limit");

endmodule

@@ test/pidpl_checker.sv @@
`timescale 1ns / 1ps

module pidpl_checker
    import pidpl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [15:0]                measurement,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [DRIVE_WIDTH-1:0]     drive,
    input  logic                       saturated,
    output int                         mismatches,
    output int                         outstanding
);

    typedef struct packed {
        logic [DRIVE_WIDTH-1:0] drive;
        logic                   saturated;
    } drive_result_t;

    localparam int              FRACTION_BITS = 24;
    localparam longint          DRIVE_CEILING = 127;
    localparam longint unsigned PRODUCT_CAP   = 64'd1 << 61;

    // controller settings as seen on the register port
    logic signed [SETPOINT_WIDTH-1:0] target;
    logic [GAIN_WIDTH-1:0]            kp;
    logic [GAIN_WIDTH-1:0]            ki;
    logic [GAIN_WIDTH-1:0]            kd;
    logic [WINDOW_WIDTH-1:0]          window;
    logic [LIMIT_WIDTH-1:0]           limit;

    // loop memory
    logic signed [16:0]          last_error;
    logic signed [SUM_WIDTH-1:0] error_total;

    drive_result_t expected_drives[$];

    // gain times value, magnitude capped, sign of the value kept
    function automatic longint scaled_term(input longint gain, input longint x);
        longint unsigned mag;
        longint unsigned product;
        mag = (x < 0) ? -x : x;
        product = gain * mag;
        if (product > PRODUCT_CAP)
            product = PRODUCT_CAP;
        return (x < 0) ? -longint'(product) : longint'(product);
    endfunction

    // one control tick: error sum update, pid sum, truncate and saturate
    function automatic drive_result_t control_step(input logic signed [15:0] sample);
        longint err;
        longint abs_err;
        longint total;
        longint raw;
        longint abs_raw;
        longint level;
        drive_result_t r;
        err = longint'(target) - longint'(sample);
        abs_err = (err < 0) ? -err : err;
        if (err != 0 && abs_err < longint'(window))
        begin
            total = longint'(error_total) + err;
            if (total > longint'(limit))
                total = longint'(limit);
            if (total < -longint'(limit))
                total = -longint'(limit);
        end
        else
        begin
            total = 0;
        end
        raw = scaled_term(longint'(kp), err) + scaled_term(longint'(ki), total)
            + scaled_term(longint'(kd), err - longint'(last_error));
        error_total = total[SUM_WIDTH-1:0];
        last_error = err[16:0];
        abs_raw = (raw < 0) ? -raw : raw;
        level = abs_raw >>> FRACTION_BITS;
        r.saturated = (level > DRIVE_CEILING);
        if (r.saturated)
            level = DRIVE_CEILING;
        if (raw < 0)
            level = -level;
        r.drive = level[DRIVE_WIDTH-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d at %0t: %s expected %0d got %0d",
                     mismatches, $realtime, what, want, got);
    endtask

    // follow register writes, predict on each sample, compare each result
    always @(posedge clk or negedge rst_n)
    begin : monitor
        drive_result_t want;
        if (!rst_n)
        begin
            target      = '0;
            kp          = '0;
            ki          = '0;
            kd          = '0;
            window      = WINDOW_RESET;
            limit       = LIMIT_RESET;
            last_error  = '0;
            error_total = '0;
            expected_drives.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_SETPOINT:          target = cfg_data[SETPOINT_WIDTH-1:0];
                    REG_PROPORTIONAL_GAIN: kp     = cfg_data[GAIN_WIDTH-1:0];
                    REG_INTEGRAL_GAIN:     ki     = cfg_data[GAIN_WIDTH-1:0];
                    REG_DERIVATIVE_GAIN:   kd     = cfg_data[GAIN_WIDTH-1:0];
                    REG_INTEGRAL_WINDOW:   window = cfg_data[WINDOW_WIDTH-1:0];
                    REG_INTEGRAL_LIMIT:    limit  = cfg_data[LIMIT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_drives.push_back(control_step(measurement));
            if (out_valid && out_ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    note_mismatch("result transaction with nothing pending", 0,
                                  int'($signed(drive)));
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (drive !== want.drive)
                        note_mismatch("drive", int'($signed(want.drive)),
                                      int'($signed(drive)));
                    if (saturated !== want.saturated)
                        note_mismatch("saturated", int'(want.saturated), int'(saturated));
                end
            end
            outstanding = expected_drives.size();
        end
    end

endmodule

@@ test/pid_position_loop_tb.sv @@
`timescale 1ns / 1ps

module pid_position_loop_tb;
    import pidpl_pkg::*;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LOW  = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HIGH = 3'd7;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [15:0]                measurement = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [DRIVE_WIDTH-1:0]     drive;
    logic                       saturated;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int stall_left = 0;

    logic signed [15:0] target_now = '0;
    logic [15:0]        window_now = 16'd200;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pid_position_loop dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .saturated   (saturated)
    );

    pidpl_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .measurement (measurement),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive       (drive),
        .saturated   (saturated),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // runaway guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("pid_position_loop verification failed");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready = 1'b0;
            stall_left--;
        end
        else if (receiver_idle_pct != 0 && $urandom_range(0, 99) < receiver_idle_pct)
        begin
            out_ready = 1'b0;
            stall_left = $urandom_range(1, 8) - 1;
        end
        else
        begin
            out_ready = 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // one sample transaction, with an optional idle burst ahead of it
    task automatic send_sample(input logic [15:0] sample);
        int burst;
        if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            burst = $urandom_range(1, 8);
            repeat (burst) @(negedge clk);
        end
        in_valid = 1'b1;
        measurement = sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // hold off until every result is back and the pipe is empty
    task automatic drain_pipeline();
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_gain(input logic [31:0] span);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    initial
    begin
        logic [31:0] data;
        logic [15:0] sample;
        int          span;
        int          offset;
        int          pick;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset gains are zero: every drive is zero
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);

        // moderate gains, window 200, limit 1000
        drain_pipeline();
        write_reg(REG_SETPOINT, 32'd0);
        write_reg(REG_PROPORTIONAL_GAIN, 32'h0100_0000);
        write_reg(REG_INTEGRAL_GAIN, 32'h0010_0000);
        write_reg(REG_DERIVATIVE_GAIN, 32'h0080_0000);
        write_reg(REG_INTEGRAL_WINDOW, 32'd200);
        write_reg(REG_INTEGRAL_LIMIT, 32'd1000);
        write_reg(REG_SPARE_LOW, 32'hFFFF_FFFF);
        // zero error, small errors, edge of window, full-scale samples
        send_sample(16'd0);
        send_sample(-16'sd50);
        send_sample(-16'sd50);
        send_sample(-16'sd100);
        send_sample(16'sd100);
        send_sample(-16'sd199);
        send_sample(-16'sd200);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'sd5);
        send_sample(-16'sd5);

        // build up the sum, then lower the limit beneath it
        drain_pipeline();
        write_reg(REG_PROPORTIONAL_GAIN, 32'd0);
        write_reg(REG_DERIVATIVE_GAIN, 32'd0);
        write_reg(REG_INTEGRAL_GAIN, 32'h0100_0000);
        write_reg(REG_INTEGRAL_WINDOW, 32'd65535);
        send_sample(-16'sd100);
        send_sample(-16'sd100);
        send_sample(-16'sd100);
        drain_pipeline();
        write_reg(REG_INTEGRAL_LIMIT, 32'd10);
        send_sample(-16'sd1);

        // zero window keeps the sum empty
        drain_pipeline();
        write_reg(REG_INTEGRAL_WINDOW, 32'd0);
        send_sample(-16'sd5);

        // largest gains and largest errors of both signs
        drain_pipeline();
        write_reg(REG_PROPORTIONAL_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_INTEGRAL_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_DERIVATIVE_GAIN, 32'hFFFF_FFFF);
        write_reg(REG_INTEGRAL_WINDOW, 32'hFFFF_FFFF);
        write_reg(REG_INTEGRAL_LIMIT, 32'hFFFF_FFFF);
        write_reg(REG_SETPOINT, 32'h0000_8000);
        send_sample(16'h7FFF);
        drain_pipeline();
        write_reg(REG_SETPOINT, 32'hFFFF_7FFF);
        send_sample(16'h8000);

        // fractional drive truncates toward zero on both signs
        drain_pipeline();
        write_reg(REG_SETPOINT, 32'd0);
        write_reg(REG_PROPORTIONAL_GAIN, 32'h0080_0000);
        write_reg(REG_INTEGRAL_GAIN, 32'd0);
        write_reg(REG_DERIVATIVE_GAIN, 32'd0);
        send_sample(16'sd1);
        send_sample(-16'sd3);

        // random phases, each with its own settings
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_pipeline();
            if (phase == 0)
            begin
                target_now = 16'sh7FFF;
                window_now = 16'hFFFF;
                write_reg(REG_INTEGRAL_LIMIT, 32'h00FF_FFFF);
                write_reg(REG_PROPORTIONAL_GAIN, 32'hFFFF_FFFF);
                write_reg(REG_INTEGRAL_GAIN, $urandom_range(0, 32'h0004_0000));
                write_reg(REG_DERIVATIVE_GAIN, $urandom_range(0, 32'h0100_0000));
            end
            else if (phase == 1)
            begin
                target_now = 16'sh8000;
                window_now = 16'd0;
                write_reg(REG_INTEGRAL_LIMIT, 32'd0);
                write_reg(REG_PROPORTIONAL_GAIN, 32'd0);
                write_reg(REG_INTEGRAL_GAIN, 32'd0);
                write_reg(REG_DERIVATIVE_GAIN, $urandom_range(0, 32'h0100_0000));
            end
            else
            begin
                target_now = 16'($urandom);
                case ($urandom_range(0, 3))
                    0:       window_now = 16'd0;
                    1:       window_now = 16'hFFFF;
                    default: window_now = 16'($urandom_range(1, 400));
                endcase
                data = $urandom;
                case ($urandom_range(0, 3))
                    0:       data[23:0] = 24'd0;
                    1:       data[23:0] = 24'hFF_FFFF;
                    default: data[23:0] = 24'($urandom_range(1, 5000));
                endcase
                write_reg(REG_INTEGRAL_LIMIT, data);
                write_reg(REG_PROPORTIONAL_GAIN, pick_gain(32'h0100_0000));
                write_reg(REG_INTEGRAL_GAIN, pick_gain(32'h0004_0000));
                write_reg(REG_DERIVATIVE_GAIN, pick_gain(32'h0100_0000));
            end
            data = $urandom;
            data[15:0] = target_now;
            write_reg(REG_SETPOINT, data);
            data = $urandom;
            data[15:0] = window_now;
            write_reg(REG_INTEGRAL_WINDOW, data);
            write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_LOW : REG_SPARE_HIGH, $urandom);

            // idle levels per phase, none at all in the closing phase
            if (phase == PHASES - 1)
            begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                sender_idle_pct = pick * 15;
                pick = $urandom_range(0, 2);
                receiver_idle_pct = pick * 15;
            end

            span = int'(window_now) + 4;
            if (span > 2000)
                span = 2000;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    drain_pipeline();
                pick = $urandom_range(0, 99);
                if (pick < 5)
                begin
                    sample = target_now;
                end
                else if (pick < 80)
                begin
                    offset = int'($urandom_range(0, 2 * span)) - span;
                    sample = 16'(int'(target_now) - offset);
                end
                else
                begin
                    sample = 16'($urandom);
                end
                send_sample(sample);
            end
        end

        // wait for the last results, then let the pipe settle
        in_valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("pid_position_loop verification clean");
        else
            $display("pid_position_loop verification failed");
        $finish;
    end

endmodule
